### sv/shortest_job_first_schedule_top_assert.svh
// Assertion macros for the shortest-job-first scheduler.
// Used by the datapath; expects clk and arst_n in scope where expanded.
`ifndef SHORTEST_JOB_FIRST_SCHEDULE_TOP_ASSERT_SVH
`define SHORTEST_JOB_FIRST_SCHEDULE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SJFS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SJFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/sjfs_pkg.sv
// Shared types and constants of the shortest-job-first scheduler.
// No dependencies; used by sjfs_ctrl, sjfs_datapath and the top level.
package sjfs_pkg;

	localparam int ID_W    = 16;
	localparam int BURST_W = 16;
	localparam int TIME_W  = 21;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_PUT   = 4'b1000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic wr;        // accepted request: store job
		logic scan_clr;  // start a fresh minimum search
		logic rd_en;     // issue one table read of the search
		logic put;       // load the found job into the result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic rd_last;   // current read address is the last stored job
		logic emit_last; // next result is the final one of the batch
		logic out_free;  // result register can take a new result
	} status_t;

endpackage

### sv/sjfs_ctrl.sv
// Controller state machine of the shortest-job-first scheduler.
// Depends on sjfs_pkg for the state, command and status types.
module sjfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               batch_end,
	output logic               in_ready,
	input  sjfs_pkg::status_t  status,
	output sjfs_pkg::cmd_t     cmd
);

	sjfs_pkg::state_t state_q, state_next;

	// Next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			sjfs_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.wr   = in_valid;
				if (in_valid && batch_end) begin
					cmd.scan_clr = 1'b1;
					state_next   = sjfs_pkg::ST_SCAN;
				end
			end
			sjfs_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (status.rd_last) begin
					state_next = sjfs_pkg::ST_FLUSH;
				end
			end
			sjfs_pkg::ST_FLUSH: begin
				state_next = sjfs_pkg::ST_PUT;
			end
			sjfs_pkg::ST_PUT: begin
				if (status.out_free) begin
					cmd.put = 1'b1;
					if (status.emit_last) begin
						state_next = sjfs_pkg::ST_LOAD;
					end else begin
						cmd.scan_clr = 1'b1;
						state_next   = sjfs_pkg::ST_SCAN;
					end
				end
			end
			default: begin
				state_next = sjfs_pkg::ST_LOAD;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sjfs_pkg::ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

### sv/sjfs_datapath.sv
// Datapath of the shortest-job-first scheduler: job table, minimum search,
// time accumulator and result register. Depends on sjfs_pkg and the assert header.
`include "shortest_job_first_schedule_top_assert.svh"

module sjfs_datapath #(
	parameter int MAX_JOBS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sjfs_pkg::cmd_t                  cmd,
	output sjfs_pkg::status_t               status,
	input  logic [sjfs_pkg::ID_W-1:0]       job_id,
	input  logic [sjfs_pkg::BURST_W-1:0]    burst_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sjfs_pkg::ID_W-1:0]       out_id,
	output logic [sjfs_pkg::BURST_W-1:0]    out_burst,
	output logic [sjfs_pkg::TIME_W-1:0]     wait_time,
	output logic [sjfs_pkg::TIME_W-1:0]     turnaround,
	output logic                            last_out,
	output logic                            dropped
);

	localparam int IW    = $clog2(MAX_JOBS);
	localparam int CW    = $clog2(MAX_JOBS + 1);
	localparam int KW    = sjfs_pkg::BURST_W + IW;
	localparam int EW    = sjfs_pkg::ID_W + sjfs_pkg::BURST_W;
	localparam int ACC_W = sjfs_pkg::BURST_W + 1 + IW;
	localparam int SUM_W = (ACC_W > sjfs_pkg::TIME_W) ? ACC_W : sjfs_pkg::TIME_W;

	// Job table, {id, burst} per entry
	logic [EW-1:0] mem [MAX_JOBS];

	logic [CW-1:0]  cnt_q;
	logic           ovf_q;
	logic           full;
	logic [IW-1:0]  rd_idx_q;
	logic [EW-1:0]  rdata_s1;
	logic [IW-1:0]  idx_s1;
	logic           vld_s1;
	logic [KW-1:0]  key_s1;
	logic           take;
	logic [KW-1:0]  best_key_q;
	logic [sjfs_pkg::ID_W-1:0] best_id_q;
	logic           best_vld_q;
	logic [KW-1:0]  prev_key_q;
	logic           have_prev_q;
	logic [CW-1:0]  emit_cnt_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] acc_next;
	logic [sjfs_pkg::BURST_W-1:0] best_burst;

	function automatic logic [sjfs_pkg::TIME_W-1:0] sat_time(input logic [SUM_W-1:0] t);
		logic [sjfs_pkg::TIME_W-1:0] r;
		if (t > SUM_W'(sjfs_pkg::TIME_MAX)) begin
			r = sjfs_pkg::TIME_MAX;
		end else begin
			r = t[sjfs_pkg::TIME_W-1:0];
		end
		return r;
	endfunction

	assign full       = (cnt_q == CW'(MAX_JOBS));
	assign key_s1     = {rdata_s1[sjfs_pkg::BURST_W-1:0], idx_s1};
	assign best_burst = best_key_q[KW-1:IW];
	assign acc_next   = acc_q + SUM_W'(best_burst);

	// Take the smallest (burst, arrival) key above the one emitted last
	assign take = vld_s1 && (!have_prev_q || (key_s1 > prev_key_q)) &&
		(!best_vld_q || (key_s1 < best_key_q));

	assign status.rd_last   = ((CW'(rd_idx_q) + CW'(1)) == cnt_q);
	assign status.emit_last = ((emit_cnt_q + CW'(1)) == cnt_q);
	assign status.out_free  = !out_valid || out_ready;

	// Write table on a stored request, read one entry per search step
	always_ff @(posedge clk) begin
		if (cmd.wr && !full) begin
			mem[cnt_q[IW-1:0]] <= {job_id, burst_time};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_idx_q];
			idx_s1   <= rd_idx_q;
		end
	end

	// Count jobs, flag overflow, clear at the end of the batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.put && status.emit_last) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.wr) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	// Advance the search address and track the running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cmd.scan_clr) begin
				rd_idx_q   <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
				if (take) begin
					best_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key_s1;
			best_id_q  <= rdata_s1[EW-1:sjfs_pkg::BURST_W];
		end
	end

	// Accumulate waiting time and remember the emitted key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			emit_cnt_q  <= '0;
			have_prev_q <= 1'b0;
			prev_key_q  <= '0;
		end else if (cmd.put) begin
			if (status.emit_last) begin
				acc_q       <= '0;
				emit_cnt_q  <= '0;
				have_prev_q <= 1'b0;
			end else begin
				acc_q       <= acc_next;
				emit_cnt_q  <= emit_cnt_q + CW'(1);
				have_prev_q <= 1'b1;
				prev_key_q  <= best_key_q;
			end
		end
	end

	// Result register: load on put, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.put) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_id     <= best_id_q;
			out_burst  <= best_burst;
			wait_time  <= sat_time(acc_q);
			turnaround <= sat_time(acc_next);
			last_out   <= status.emit_last;
			dropped    <= ovf_q;
		end
	end

	`SJFS_ASSERT_SAME(a_put_room, cmd.put, !out_valid || out_ready, "result register overrun")
	`SJFS_ASSERT_SAME(a_put_found, cmd.put, best_vld_q, "result issued without a found job")
	`SJFS_ASSERT_SAME(a_rd_range, cmd.rd_en, CW'(rd_idx_q) < cnt_q, "read beyond stored jobs")
	`SJFS_ASSERT_NEXT(a_full_ovf, cmd.wr && full, ovf_q, "discarded job not flagged")
	`SJFS_ASSERT_NEXT(a_batch_clr, cmd.put && status.emit_last, cnt_q == '0 && !ovf_q,
		"batch state not cleared after final result")

endmodule

### sv/shortest_job_first_schedule_top.sv
// Non-preemptive shortest-job-first scheduler. Jobs (id, burst) load one per
// cycle, while in_ready is high, into a table of MAX_JOBS entries; the request
// flagged batch_end closes the batch, and jobs beyond capacity are discarded
// and flagged as dropped on every result. Results come out in ascending burst
// order, ties in arrival order, with waiting and turnaround times saturated at
// 21 bits. Each result is found by a full scan of the single-port job table:
// for a batch of n jobs, n table reads, then a flush state and an emit state,
// the emit waiting while the output is stalled; no request is taken while
// results are being found. The next batch may start loading while the final
// result still waits in the output register.
// Depends on sjfs_pkg, sjfs_ctrl and sjfs_datapath.
module shortest_job_first_schedule_top #(
	parameter int MAX_JOBS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sjfs_pkg::ID_W-1:0]       job_id,
	input  logic [sjfs_pkg::BURST_W-1:0]    burst_time,
	input  logic                            batch_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sjfs_pkg::ID_W-1:0]       out_id,
	output logic [sjfs_pkg::BURST_W-1:0]    out_burst,
	output logic [sjfs_pkg::TIME_W-1:0]     wait_time,
	output logic [sjfs_pkg::TIME_W-1:0]     turnaround,
	output logic                            last_out,
	output logic                            dropped
);

	sjfs_pkg::cmd_t    cmd;
	sjfs_pkg::status_t status;

	// Sequence load, search and emit
	sjfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.batch_end (batch_end),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Store jobs, find the next one, compute times
	sjfs_datapath #(
		.MAX_JOBS (MAX_JOBS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.job_id     (job_id),
		.burst_time (burst_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_id     (out_id),
		.out_burst  (out_burst),
		.wait_time  (wait_time),
		.turnaround (turnaround),
		.last_out   (last_out),
		.dropped    (dropped)
	);

endmodule
